// ===== src/mahd_pkg.sv =====
// shared types, constants and lookup tables for the mpeg audio header decoder
package mahd_pkg;

    localparam int KBPS_W      = 9;
    localparam int FS_W        = 16;
    localparam int LEN_W       = 12;
    localparam int COEF_W      = 13;
    localparam int NUMER_W     = 20;
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 29;

    localparam logic [10:0] SYNC_ALL_ONES = 11'h7FF;

    localparam logic [1:0] VER_MPEG25   = 2'd0;
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] VER_MPEG2    = 2'd2;
    localparam logic [1:0] VER_MPEG1    = 2'd3;

    localparam logic [1:0] LAYER_RESERVED = 2'd0;
    localparam logic [1:0] LAYER_III      = 2'd1;
    localparam logic [1:0] LAYER_II       = 2'd2;
    localparam logic [1:0] LAYER_I        = 2'd3;

    localparam logic [1:0] SRATE_44K1     = 2'd0;
    localparam logic [1:0] SRATE_48K      = 2'd1;
    localparam logic [1:0] SRATE_32K      = 2'd2;
    localparam logic [1:0] SRATE_RESERVED = 2'd3;

    localparam logic [3:0] BIDX_FREE = 4'd0;
    localparam logic [3:0] BIDX_BAD  = 4'd15;

    localparam logic [KBPS_W-1:0] BR_V1_L1 [16] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam logic [KBPS_W-1:0] BR_V1_L2 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [KBPS_W-1:0] BR_V1_L3 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [KBPS_W-1:0] BR_V2_L1 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam logic [KBPS_W-1:0] BR_V2_L23 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

    typedef enum logic [2:0] {
        DIV_8,
        DIV_12,
        DIV_16,
        DIV_24,
        DIV_32,
        DIV_48,
        DIV_441
    } div_sel_t;

    typedef struct packed {
        logic [1:0] version_id;
        logic [1:0] layer_id;
        logic       protection_bit;
        logic       padding_bit;
        logic [1:0] channel_mode;
        logic [1:0] mode_extension;
        logic [1:0] emphasis;
        logic [2:0] misc_flags;
    } hdr_fields_t;

    typedef struct packed {
        logic              ok;
        logic              layer_one;
        logic [KBPS_W-1:0] kbps;
        logic [FS_W-1:0]   fs;
    } rate_info_t;

    function automatic logic [KBPS_W-1:0] kbps_lookup(
        input logic [1:0] ver,
        input logic [1:0] lay,
        input logic [3:0] idx
    );
        logic [KBPS_W-1:0] kbps;
        kbps = '0;
        if (ver == VER_MPEG1)
        begin
            unique case (lay)
                LAYER_I:   kbps = BR_V1_L1[idx];
                LAYER_II:  kbps = BR_V1_L2[idx];
                LAYER_III: kbps = BR_V1_L3[idx];
                default:   kbps = '0;
            endcase
        end
        else
        begin
            unique case (lay) inside
                LAYER_I:             kbps = BR_V2_L1[idx];
                LAYER_II, LAYER_III: kbps = BR_V2_L23[idx];
                default:             kbps = '0;
            endcase
        end
        return kbps;
    endfunction

    function automatic logic [FS_W-1:0] fs_lookup(
        input logic [1:0] ver,
        input logic [1:0] sidx
    );
        logic [FS_W-1:0] fs;
        fs = '0;
        unique case (ver)
            VER_MPEG1:
            begin
                unique case (sidx)
                    SRATE_44K1: fs = 16'd44100;
                    SRATE_48K:  fs = 16'd48000;
                    SRATE_32K:  fs = 16'd32000;
                    default:    fs = '0;
                endcase
            end
            VER_MPEG2:
            begin
                unique case (sidx)
                    SRATE_44K1: fs = 16'd22050;
                    SRATE_48K:  fs = 16'd24000;
                    SRATE_32K:  fs = 16'd16000;
                    default:    fs = '0;
                endcase
            end
            VER_MPEG25:
            begin
                unique case (sidx)
                    SRATE_44K1: fs = 16'd11025;
                    SRATE_48K:  fs = 16'd12000;
                    SRATE_32K:  fs = 16'd8000;
                    default:    fs = '0;
                endcase
            end
            default: fs = '0;
        endcase
        return fs;
    endfunction

    // ceil(2**RECIP_SHIFT / d), exact quotient for numerators below 2**NUMER_W
    function automatic logic [RECIP_W-1:0] recip_of(input div_sel_t sel);
        logic [RECIP_W-1:0] r;
        unique case (sel)
            DIV_8:   r = 27'd67108864;
            DIV_12:  r = 27'd44739243;
            DIV_16:  r = 27'd33554432;
            DIV_24:  r = 27'd22369622;
            DIV_32:  r = 27'd16777216;
            DIV_48:  r = 27'd11184811;
            DIV_441: r = 27'd1217395;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/mahd_decode.sv =====
// stage 1: field unpack, header checks, table lookups and divider setup
module mahd_decode (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [31:0]                header_word,
    output logic                       out_valid,
    output mahd_pkg::hdr_fields_t      out_fields,
    output mahd_pkg::rate_info_t       out_info,
    output logic [mahd_pkg::COEF_W-1:0] out_coef,
    output mahd_pkg::div_sel_t         out_div
);
    import mahd_pkg::*;

    logic [10:0] sync;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [3:0]  bidx;
    logic [1:0]  sidx;
    logic [7:0]  base;
    logic [5:0]  mult;

    logic          valid_reg;
    hdr_fields_t   fields_reg, fields_next;
    rate_info_t    info_reg, info_next;
    logic [COEF_W-1:0] coef_reg, coef_next;
    div_sel_t      div_reg, div_next;

    always_comb
    begin
        sync = header_word[31:21];
        ver  = header_word[20:19];
        lay  = header_word[18:17];
        bidx = header_word[15:12];
        sidx = header_word[11:10];

        fields_next.version_id     = ver;
        fields_next.layer_id       = lay;
        fields_next.protection_bit = header_word[16];
        fields_next.padding_bit    = header_word[9];
        fields_next.channel_mode   = header_word[7:6];
        fields_next.mode_extension = header_word[5:4];
        fields_next.emphasis       = header_word[1:0];
        fields_next.misc_flags     = {header_word[8], header_word[3], header_word[2]};

        info_next.ok = (sync == SYNC_ALL_ONES) && (ver != VER_RESERVED)
                    && (lay != LAYER_RESERVED) && (bidx != BIDX_FREE)
                    && (bidx != BIDX_BAD) && (sidx != SRATE_RESERVED);
        info_next.layer_one = (lay == LAYER_I);
        info_next.kbps      = kbps_lookup(ver, lay, bidx);
        info_next.fs        = fs_lookup(ver, sidx);

        // slot coefficient
        if (lay == LAYER_I)
            base = 8'd12;
        else if (lay == LAYER_II || ver == VER_MPEG1)
            base = 8'd144;
        else
            base = 8'd72;

        // 44.1 kHz family divides by 441 after scaling up
        mult = 6'd1;
        div_next = DIV_441;
        unique case (sidx)
            SRATE_44K1:
            begin
                div_next = DIV_441;
                if (ver == VER_MPEG1)
                    mult = 6'd10;
                else if (ver == VER_MPEG2)
                    mult = 6'd20;
                else
                    mult = 6'd40;
            end
            SRATE_48K:
            begin
                if (ver == VER_MPEG1)
                    div_next = DIV_48;
                else if (ver == VER_MPEG2)
                    div_next = DIV_24;
                else
                    div_next = DIV_12;
            end
            SRATE_32K:
            begin
                if (ver == VER_MPEG1)
                    div_next = DIV_32;
                else if (ver == VER_MPEG2)
                    div_next = DIV_16;
                else
                    div_next = DIV_8;
            end
            default: div_next = DIV_441;
        endcase

        coef_next = COEF_W'(base) * COEF_W'(mult);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        fields_reg <= fields_next;
        info_reg   <= info_next;
        coef_reg   <= coef_next;
        div_reg    <= div_next;
    end

    assign out_valid  = valid_reg;
    assign out_fields = fields_reg;
    assign out_info   = info_reg;
    assign out_coef   = coef_reg;
    assign out_div    = div_reg;

endmodule

// ===== src/mahd_scale.sv =====
// stage 2: numerator multiply, coefficient times bitrate
module mahd_scale (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  mahd_pkg::hdr_fields_t        in_fields,
    input  mahd_pkg::rate_info_t         in_info,
    input  logic [mahd_pkg::COEF_W-1:0]  in_coef,
    input  mahd_pkg::div_sel_t           in_div,
    output logic                         out_valid,
    output mahd_pkg::hdr_fields_t        out_fields,
    output mahd_pkg::rate_info_t         out_info,
    output logic [mahd_pkg::NUMER_W-1:0] out_numer,
    output mahd_pkg::div_sel_t           out_div
);
    import mahd_pkg::*;

    localparam int PROD_W = COEF_W + KBPS_W;

    logic [PROD_W-1:0]  prod;
    logic               valid_reg;
    hdr_fields_t        fields_reg;
    rate_info_t         info_reg;
    logic [NUMER_W-1:0] numer_reg, numer_next;
    div_sel_t           div_reg;

    always_comb
    begin
        prod       = PROD_W'(in_coef) * PROD_W'(in_info.kbps);
        numer_next = prod[NUMER_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        fields_reg <= in_fields;
        info_reg   <= in_info;
        numer_reg  <= numer_next;
        div_reg    <= in_div;
    end

    assign out_valid  = valid_reg;
    assign out_fields = fields_reg;
    assign out_info   = info_reg;
    assign out_numer  = numer_reg;
    assign out_div    = div_reg;

endmodule

// ===== src/mahd_recip.sv =====
// stage 3: division by the sample-rate divisor through a reciprocal multiply
module mahd_recip (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  mahd_pkg::hdr_fields_t        in_fields,
    input  mahd_pkg::rate_info_t         in_info,
    input  logic [mahd_pkg::NUMER_W-1:0] in_numer,
    input  mahd_pkg::div_sel_t           in_div,
    output logic                         out_valid,
    output mahd_pkg::hdr_fields_t        out_fields,
    output mahd_pkg::rate_info_t         out_info,
    output logic [mahd_pkg::LEN_W-1:0]   out_quot
);
    import mahd_pkg::*;

    localparam int PROD_W = NUMER_W + RECIP_W;

    logic [PROD_W-1:0] prod;
    logic              valid_reg;
    hdr_fields_t       fields_reg;
    rate_info_t        info_reg;
    logic [LEN_W-1:0]  quot_reg, quot_next;

    always_comb
    begin
        prod      = PROD_W'(in_numer) * PROD_W'(recip_of(in_div));
        quot_next = prod[RECIP_SHIFT+LEN_W-1:RECIP_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        fields_reg <= in_fields;
        info_reg   <= in_info;
        quot_reg   <= quot_next;
    end

    assign out_valid  = valid_reg;
    assign out_fields = fields_reg;
    assign out_info   = info_reg;
    assign out_quot   = quot_reg;

endmodule

// ===== src/mpeg_audio_header_decoder.sv =====
// top level: four-stage mpeg audio frame header decoder with registered results
// One 32-bit header word is taken on every cycle that start is high; busy is
// always low. Each result appears on the result ports for one cycle, marked by
// done, in transfer order.
// The four stages are field decode with table lookup, the bitrate multiply,
// the reciprocal multiply that divides by the sample rate, and the padding and
// final check. Invalid headers give valid_res low with zero bitrate, rate and
// length; the raw fields are still passed through. The receiver cannot stall.
module mpeg_audio_header_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] header_word,
    output logic        done,
    output logic        valid_res,
    output logic [1:0]  version_id,
    output logic [1:0]  layer_id,
    output logic        protection_bit,
    output logic [8:0]  bitrate_kbps,
    output logic [15:0] sample_rate_hz,
    output logic [11:0] frame_length_bytes,
    output logic        padding_bit,
    output logic [1:0]  channel_mode,
    output logic [1:0]  mode_extension,
    output logic [1:0]  emphasis,
    output logic [2:0]  misc_flags
);
    import mahd_pkg::*;

    logic               s1_valid;
    hdr_fields_t        s1_fields;
    rate_info_t         s1_info;
    logic [COEF_W-1:0]  s1_coef;
    div_sel_t           s1_div;

    logic               s2_valid;
    hdr_fields_t        s2_fields;
    rate_info_t         s2_info;
    logic [NUMER_W-1:0] s2_numer;
    div_sel_t           s2_div;

    logic               s3_valid;
    hdr_fields_t        s3_fields;
    rate_info_t         s3_info;
    logic [LEN_W-1:0]   s3_quot;

    logic [LEN_W-1:0]   len_pad;
    logic [LEN_W-1:0]   len_next;
    logic               ok_next;

    logic               done_reg;
    logic               ok_reg;
    hdr_fields_t        fields_reg;
    logic [KBPS_W-1:0]  kbps_reg, kbps_next;
    logic [FS_W-1:0]    fs_reg, fs_next;
    logic [LEN_W-1:0]   len_reg;

    assign busy = 1'b0;

    mahd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .header_word (header_word),
        .out_valid   (s1_valid),
        .out_fields  (s1_fields),
        .out_info    (s1_info),
        .out_coef    (s1_coef),
        .out_div     (s1_div)
    );

    mahd_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid),
        .in_fields  (s1_fields),
        .in_info    (s1_info),
        .in_coef    (s1_coef),
        .in_div     (s1_div),
        .out_valid  (s2_valid),
        .out_fields (s2_fields),
        .out_info   (s2_info),
        .out_numer  (s2_numer),
        .out_div    (s2_div)
    );

    mahd_recip u_recip (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid),
        .in_fields  (s2_fields),
        .in_info    (s2_info),
        .in_numer   (s2_numer),
        .in_div     (s2_div),
        .out_valid  (s3_valid),
        .out_fields (s3_fields),
        .out_info   (s3_info),
        .out_quot   (s3_quot)
    );

    always_comb
    begin
        len_pad = s3_quot + LEN_W'(s3_fields.padding_bit);
        // layer I counts four-byte slots
        if (s3_info.layer_one)
            len_next = {len_pad[LEN_W-3:0], 2'b00};
        else
            len_next = len_pad;
        ok_next = s3_info.ok && (s3_info.kbps != '0) && (s3_info.fs != '0)
               && (len_next != '0);
        if (!ok_next)
        begin
            len_next  = '0;
            kbps_next = '0;
            fs_next   = '0;
        end
        else
        begin
            kbps_next = s3_info.kbps;
            fs_next   = s3_info.fs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s3_valid;
    end

    always_ff @(posedge clk)
    begin
        ok_reg     <= ok_next;
        fields_reg <= s3_fields;
        kbps_reg   <= kbps_next;
        fs_reg     <= fs_next;
        len_reg    <= len_next;
    end

    assign done               = done_reg;
    assign valid_res          = ok_reg;
    assign version_id         = fields_reg.version_id;
    assign layer_id           = fields_reg.layer_id;
    assign protection_bit     = fields_reg.protection_bit;
    assign bitrate_kbps       = kbps_reg;
    assign sample_rate_hz     = fs_reg;
    assign frame_length_bytes = len_reg;
    assign padding_bit        = fields_reg.padding_bit;
    assign channel_mode       = fields_reg.channel_mode;
    assign mode_extension     = fields_reg.mode_extension;
    assign emphasis           = fields_reg.emphasis;
    assign misc_flags         = fields_reg.misc_flags;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !valid_res |-> bitrate_kbps == '0 && sample_rate_hz == '0
                               && frame_length_bytes == '0)
        else $error("invalid header result carries nonzero rate or length");

    a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && valid_res |-> frame_length_bytes != '0 && sample_rate_hz != '0
                              && bitrate_kbps != '0)
        else $error("valid header result with zero rate or length");

    a_valid_codes: assert property (@(posedge clk) disable iff (!rst_n)
        done && valid_res |-> version_id != VER_RESERVED
                              && layer_id != LAYER_RESERVED)
        else $error("reserved version or layer reported valid");

endmodule

// ===== verif/mpeg_audio_header_decoder_tb.sv =====
// self-checking testbench for the mpeg audio frame header decoder
module mpeg_audio_header_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mahd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int N_DIRECTED     = 23;
    localparam int RANDOM_PER_PHASE = 300;

    localparam int unsigned KBPS_M1_L1 [16] = '{
        0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0};
    localparam int unsigned KBPS_M1_L2 [16] = '{
        0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0};
    localparam int unsigned KBPS_M1_L3 [16] = '{
        0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0};
    localparam int unsigned KBPS_M2_L1 [16] = '{
        0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0};
    localparam int unsigned KBPS_M2_L23 [16] = '{
        0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0};

    typedef struct packed {
        logic              ok;
        logic [1:0]        ver;
        logic [1:0]        lay;
        logic              prot;
        logic [KBPS_W-1:0] kbps;
        logic [FS_W-1:0]   fs;
        logic [LEN_W-1:0]  len;
        logic              pad;
        logic [1:0]        chm;
        logic [1:0]        mext;
        logic [1:0]        emph;
        logic [2:0]        misc;
    } frame_res_t;

    typedef struct packed {
        logic [31:0] word;
        frame_res_t  res;
    } header_expect_t;

    typedef struct {
        logic [31:0] word;
        bit          typed;
        bit          ok;
        int unsigned kbps;
        int unsigned fs;
        int unsigned len;
    } header_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] header_word;
    logic        done;
    logic        valid_res;
    logic [1:0]  version_id;
    logic [1:0]  layer_id;
    logic        protection_bit;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [11:0] frame_length_bytes;
    logic        padding_bit;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic [1:0]  emphasis;
    logic [2:0]  misc_flags;

    header_expect_t want_hold;
    header_expect_t pending_frames [$];
    header_row_t    header_rows [N_DIRECTED];
    int             mismatch_count = 0;

    mpeg_audio_header_decoder uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .header_word        (header_word),
        .done               (done),
        .valid_res          (valid_res),
        .version_id         (version_id),
        .layer_id           (layer_id),
        .protection_bit     (protection_bit),
        .bitrate_kbps       (bitrate_kbps),
        .sample_rate_hz     (sample_rate_hz),
        .frame_length_bytes (frame_length_bytes),
        .padding_bit        (padding_bit),
        .channel_mode       (channel_mode),
        .mode_extension     (mode_extension),
        .emphasis           (emphasis),
        .misc_flags         (misc_flags)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] mk_header(
        input logic [10:0] sync,
        input logic [1:0]  ver,
        input logic [1:0]  lay,
        input logic        prot,
        input logic [3:0]  bidx,
        input logic [1:0]  sidx,
        input logic        pad,
        input logic [8:0]  tail
    );
        return {sync, ver, lay, prot, bidx, sidx, pad, tail};
    endfunction

    function automatic int unsigned table_kbps(
        input logic [1:0] ver,
        input logic [1:0] lay,
        input logic [3:0] idx
    );
        int unsigned kbps;
        kbps = 0;
        if (ver == VER_MPEG1)
        begin
            case (lay)
                LAYER_I:   kbps = KBPS_M1_L1[idx];
                LAYER_II:  kbps = KBPS_M1_L2[idx];
                LAYER_III: kbps = KBPS_M1_L3[idx];
                default:   kbps = 0;
            endcase
        end
        else
        begin
            case (lay)
                LAYER_I:             kbps = KBPS_M2_L1[idx];
                LAYER_II, LAYER_III: kbps = KBPS_M2_L23[idx];
                default:             kbps = 0;
            endcase
        end
        return kbps;
    endfunction

    function automatic int unsigned table_fs(input logic [1:0] ver, input logic [1:0] sidx);
        int unsigned base;
        case (sidx)
            SRATE_44K1: base = 44100;
            SRATE_48K:  base = 48000;
            SRATE_32K:  base = 32000;
            default:    base = 0;
        endcase
        case (ver)
            VER_MPEG1:  return base;
            VER_MPEG2:  return base / 2;
            VER_MPEG25: return base / 4;
            default:    return 0;
        endcase
    endfunction

    // pass-through fields only, computed fields left at zero
    function automatic frame_res_t raw_fields(input logic [31:0] w);
        frame_res_t r;
        r      = '0;
        r.ver  = w[20:19];
        r.lay  = w[18:17];
        r.prot = w[16];
        r.pad  = w[9];
        r.chm  = w[7:6];
        r.mext = w[5:4];
        r.emph = w[1:0];
        r.misc = {w[8], w[3], w[2]};
        return r;
    endfunction

    function automatic frame_res_t decode_header(input logic [31:0] w);
        frame_res_t  r;
        int unsigned kbps;
        int unsigned fs;
        int unsigned bps;
        int unsigned len;
        r   = raw_fields(w);
        len = 0;
        if (w[31:21] == SYNC_ALL_ONES && r.ver != VER_RESERVED && r.lay != LAYER_RESERVED &&
            w[15:12] != BIDX_FREE && w[15:12] != BIDX_BAD && w[11:10] != SRATE_RESERVED)
        begin
            kbps = table_kbps(r.ver, r.lay, w[15:12]);
            fs   = table_fs(r.ver, w[11:10]);
            if (kbps != 0 && fs != 0)
            begin
                bps = kbps * 1000;
                if (r.lay == LAYER_I)
                    len = ((12 * bps) / fs + r.pad) * 4;
                else if (r.lay == LAYER_II || r.ver == VER_MPEG1)
                    len = (144 * bps) / fs + r.pad;
                else
                    len = (72 * bps) / fs + r.pad;
            end
            if (kbps != 0 && fs != 0 && len != 0)
            begin
                r.ok   = 1'b1;
                r.kbps = kbps[KBPS_W-1:0];
                r.fs   = fs[FS_W-1:0];
                r.len  = len[LEN_W-1:0];
            end
        end
        return r;
    endfunction

    // mostly well-formed headers, some with one field broken, some raw noise
    function automatic logic [31:0] random_header();
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [1:0]  sidx;
        logic [3:0]  bidx;
        logic [31:0] w;
        int unsigned kind;
        int unsigned bit_pos;
        kind = $urandom_range(99);
        if (kind >= 88)
            return $urandom();
        case ($urandom_range(2))
            0:       ver = VER_MPEG25;
            1:       ver = VER_MPEG2;
            default: ver = VER_MPEG1;
        endcase
        lay  = 2'($urandom_range(3, 1));
        bidx = 4'($urandom_range(14, 1));
        sidx = 2'($urandom_range(2));
        w = mk_header(SYNC_ALL_ONES, ver, lay, 1'($urandom()), bidx, sidx,
                      1'($urandom()), 9'($urandom()));
        if (kind >= 72)
        begin
            case ($urandom_range(4))
                0:
                begin
                    bit_pos    = 21 + $urandom_range(10);
                    w[bit_pos] = ~w[bit_pos];
                end
                1:       w[20:19] = VER_RESERVED;
                2:       w[18:17] = LAYER_RESERVED;
                3:       w[15:12] = $urandom_range(1) ? BIDX_BAD : BIDX_FREE;
                default: w[11:10] = SRATE_RESERVED;
            endcase
        end
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_frame(input logic [31:0] w, input frame_res_t got, input frame_res_t want);
        if (got.ok !== want.ok)
            report_mismatch($sformatf("hdr %h valid_res got %0d want %0d", w, got.ok, want.ok));
        if (got.ver !== want.ver)
            report_mismatch($sformatf("hdr %h version_id got %0d want %0d", w, got.ver, want.ver));
        if (got.lay !== want.lay)
            report_mismatch($sformatf("hdr %h layer_id got %0d want %0d", w, got.lay, want.lay));
        if (got.prot !== want.prot)
            report_mismatch($sformatf("hdr %h protection_bit got %0d want %0d",
                                      w, got.prot, want.prot));
        if (got.kbps !== want.kbps)
            report_mismatch($sformatf("hdr %h bitrate_kbps got %0d want %0d",
                                      w, got.kbps, want.kbps));
        if (got.fs !== want.fs)
            report_mismatch($sformatf("hdr %h sample_rate_hz got %0d want %0d",
                                      w, got.fs, want.fs));
        if (got.len !== want.len)
            report_mismatch($sformatf("hdr %h frame_length_bytes got %0d want %0d",
                                      w, got.len, want.len));
        if (got.pad !== want.pad)
            report_mismatch($sformatf("hdr %h padding_bit got %0d want %0d", w, got.pad, want.pad));
        if (got.chm !== want.chm)
            report_mismatch($sformatf("hdr %h channel_mode got %0d want %0d", w, got.chm, want.chm));
        if (got.mext !== want.mext)
            report_mismatch($sformatf("hdr %h mode_extension got %0d want %0d",
                                      w, got.mext, want.mext));
        if (got.emph !== want.emph)
            report_mismatch($sformatf("hdr %h emphasis got %0d want %0d", w, got.emph, want.emph));
        if (got.misc !== want.misc)
            report_mismatch($sformatf("hdr %h misc_flags got %0d want %0d", w, got.misc, want.misc));
    endtask

    // result check first, then record the header taken at this edge
    always @(posedge clk)
    begin
        frame_res_t     got;
        header_expect_t oldest;
        if (rst_n && done)
        begin
            got = '{valid_res, version_id, layer_id, protection_bit, bitrate_kbps,
                    sample_rate_hz, frame_length_bytes, padding_bit, channel_mode,
                    mode_extension, emphasis, misc_flags};
            if (pending_frames.size() == 0)
                report_mismatch("result with no header transfer waiting");
            else
            begin
                oldest = pending_frames.pop_front();
                check_frame(oldest.word, got, oldest.res);
            end
        end
        if (rst_n && start && !busy)
            pending_frames.push_back(want_hold);
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("mpeg_audio_header_decoder verification failed");
        $finish;
    end

    task automatic send_header(input logic [31:0] w, input frame_res_t want, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        header_word <= w;
        want_hold   <= '{w, want};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_frames.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        frame_res_t  want;
        logic [31:0] w;
        int          idle_pct;

        rst_n       <= 1'b0;
        start       <= 1'b0;
        header_word <= '0;
        want_hold   <= '0;

        header_rows = '{
            '{32'h0000_0000, 1'b1, 1'b0, 0, 0, 0},
            '{32'hFFFF_FFFF, 1'b1, 1'b0, 0, 0, 0},
            '{mk_header(11'h7FE, VER_MPEG1, LAYER_III, 1'b1, 4'd9, SRATE_44K1, 1'b0, 9'h000),
              1'b1, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_RESERVED, LAYER_III, 1'b1, 4'd9, SRATE_44K1, 1'b0,
                        9'h1FF), 1'b1, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG1, LAYER_RESERVED, 1'b0, 4'd9, SRATE_44K1, 1'b1,
                        9'h0C4), 1'b1, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG1, LAYER_III, 1'b1, BIDX_FREE, SRATE_44K1, 1'b0,
                        9'h040), 1'b1, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG2, LAYER_II, 1'b1, BIDX_BAD, SRATE_48K, 1'b0,
                        9'h000), 1'b1, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG1, LAYER_I, 1'b1, 4'd5, SRATE_RESERVED, 1'b0,
                        9'h000), 1'b1, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG1, LAYER_III, 1'b1, 4'd9, SRATE_44K1, 1'b0,
                        9'h044), 1'b1, 1'b1, 128, 44100, 417},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG1, LAYER_III, 1'b1, 4'd9, SRATE_44K1, 1'b1,
                        9'h044), 1'b1, 1'b1, 128, 44100, 418},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG1, LAYER_I, 1'b0, 4'd14, SRATE_48K, 1'b1,
                        9'h1FF), 1'b1, 1'b1, 448, 48000, 452},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG1, LAYER_I, 1'b1, 4'd1, SRATE_32K, 1'b0,
                        9'h000), 1'b0, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG1, LAYER_II, 1'b0, 4'd14, SRATE_32K, 1'b0,
                        9'h0AA), 1'b0, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG1, LAYER_II, 1'b1, 4'd1, SRATE_48K, 1'b1,
                        9'h155), 1'b0, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG1, LAYER_III, 1'b0, 4'd14, SRATE_32K, 1'b1,
                        9'h100), 1'b0, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG1, LAYER_III, 1'b1, 4'd1, SRATE_48K, 1'b0,
                        9'h008), 1'b0, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG2, LAYER_I, 1'b1, 4'd14, SRATE_32K, 1'b0,
                        9'h0F0), 1'b0, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG2, LAYER_II, 1'b0, 4'd14, SRATE_44K1, 1'b1,
                        9'h00C), 1'b0, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG2, LAYER_III, 1'b1, 4'd1, SRATE_48K, 1'b0,
                        9'h0C3), 1'b0, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG25, LAYER_I, 1'b0, 4'd1, SRATE_44K1, 1'b0,
                        9'h030), 1'b0, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG25, LAYER_III, 1'b1, 4'd1, SRATE_48K, 1'b0,
                        9'h001), 1'b0, 1'b0, 0, 0, 0},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG25, LAYER_II, 1'b1, 4'd14, SRATE_32K, 1'b1,
                        9'h000), 1'b1, 1'b1, 160, 8000, 2881},
            '{mk_header(SYNC_ALL_ONES, VER_MPEG25, LAYER_III, 1'b0, 4'd14, SRATE_32K, 1'b1,
                        9'h1FF), 1'b0, 1'b0, 0, 0, 0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (header_rows[i])
        begin
            if (header_rows[i].typed)
            begin
                want      = raw_fields(header_rows[i].word);
                want.ok   = header_rows[i].ok;
                want.kbps = header_rows[i].kbps[KBPS_W-1:0];
                want.fs   = header_rows[i].fs[FS_W-1:0];
                want.len  = header_rows[i].len[LEN_W-1:0];
            end
            else
                want = decode_header(header_rows[i].word);
            send_header(header_rows[i].word, want, 22);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 22 : (phase == 1) ? 82 : 0;
            repeat (RANDOM_PER_PHASE)
            begin
                w = random_header();
                send_header(w, decode_header(w), idle_pct);
            end
            wait_results();
        end

        repeat (8) @(posedge clk);
        if (pending_frames.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_frames.size()));
        if (mismatch_count == 0)
            $display("mpeg_audio_header_decoder verification clean");
        else
            $display("mpeg_audio_header_decoder verification failed");
        $finish;
    end

endmodule
